[rtl/grs_pkg.sv]
// ----------------------------------------------------------------------------
// grs_pkg
// Shared constants, types and codes for the group reversing stream block.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int GROUP_MAX  = 16;
  localparam int DATA_WIDTH = 32;

  // field widths fixed by the interface
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;

  localparam int CNT_W   = $clog2(GROUP_MAX + 1);
  localparam int IDX_W   = $clog2(GROUP_MAX);
  localparam int K_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // two banks of GROUP_MAX entries, bank select on the top address bit
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             eos;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } bk_state_t;

endpackage

[rtl/grs_ram.sv]
// ----------------------------------------------------------------------------
// grs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/grs_front.sv]
// ----------------------------------------------------------------------------
// grs_front
// Accepts input transactions, writes them into the fill bank and issues a
// drain command when a group is complete or the sequence ends.
// ----------------------------------------------------------------------------
module grs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [grs_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [grs_pkg::VALUE_W-1:0]    value,
  input  logic                           end_of_sequence,
  input  grs_pkg::rel_t                  rel,
  output logic                           ram_we,
  output logic [grs_pkg::RAM_AW-1:0]     ram_waddr,
  output logic [grs_pkg::DATA_WIDTH-1:0] ram_wdata,
  output logic                           cmd_push,
  output grs_pkg::cmd_t                  cmd,
  output logic [grs_pkg::CNT_W-1:0]      fill_level
);

  logic [grs_pkg::CFG_W-1:0] group_size;
  logic [grs_pkg::CNT_W-1:0] fill;
  logic [grs_pkg::CNT_W-1:0] fill_next;
  logic                      fill_bank;
  logic                      fill_bank_next;
  logic [1:0]                bank_busy;
  logic [1:0]                bank_busy_next;
  logic [grs_pkg::K_W-1:0]   gs_ext;
  logic [grs_pkg::K_W-1:0]   k_eff;
  logic [grs_pkg::K_W-1:0]   fill_inc;
  logic                      accept;
  logic                      flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= grs_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      group_size <= cfg_wr_data;
    end
  end

  // saturate above GROUP_MAX, treat zero as one
  always_comb begin
    gs_ext = grs_pkg::K_W'(group_size);
    if (gs_ext > grs_pkg::K_W'(grs_pkg::GROUP_MAX)) begin
      k_eff = grs_pkg::K_W'(grs_pkg::GROUP_MAX);
    end else if (gs_ext == '0) begin
      k_eff = grs_pkg::K_W'(1);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign in_stall = bank_busy[fill_bank];
  assign accept   = in_valid && !in_stall;
  assign fill_inc = grs_pkg::K_W'(fill) + grs_pkg::K_W'(1);
  assign flush    = end_of_sequence || (fill_inc >= k_eff);

  assign ram_we    = accept;
  assign ram_waddr = {fill_bank, fill[grs_pkg::IDX_W-1:0]};
  assign ram_wdata = value[grs_pkg::DATA_WIDTH-1:0];

  assign cmd_push  = accept && flush;
  assign cmd.bank  = fill_bank;
  assign cmd.count = fill + grs_pkg::CNT_W'(1);
  assign cmd.eos   = end_of_sequence;

  assign fill_level = fill;

  always_comb begin
    fill_next      = fill;
    fill_bank_next = fill_bank;
    bank_busy_next = bank_busy;
    if (rel.valid) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (flush) begin
        fill_next                 = '0;
        fill_bank_next            = !fill_bank;
        bank_busy_next[fill_bank] = 1'b1;
      end else begin
        fill_next = fill + grs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      fill_bank <= 1'b0;
      bank_busy <= '0;
    end else begin
      fill      <= fill_next;
      fill_bank <= fill_bank_next;
      bank_busy <= bank_busy_next;
    end
  end

endmodule

[rtl/grs_cmd_queue.sv]
// ----------------------------------------------------------------------------
// grs_cmd_queue
// Short FIFO of drain commands between the fill side and the drain side.
// ----------------------------------------------------------------------------
module grs_cmd_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  grs_pkg::cmd_t              push_cmd,
  input  logic                       pop,
  output logic                       head_valid,
  output grs_pkg::cmd_t              head_cmd,
  output logic [grs_pkg::QCNT_W-1:0] count
);

  grs_pkg::cmd_t               entries [grs_pkg::QUEUE_DEPTH];
  logic [grs_pkg::QPTR_W-1:0]  wr_ptr;
  logic [grs_pkg::QPTR_W-1:0]  rd_ptr;

  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == grs_pkg::QPTR_W'(grs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + grs_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == grs_pkg::QPTR_W'(grs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + grs_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + grs_pkg::QCNT_W'(1);
        2'b01:   count <= count - grs_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/grs_back.sv]
// ----------------------------------------------------------------------------
// grs_back
// Drains one bank per command in reverse order through the RAM read port
// into the output register, honouring the receiver's stall.
// ----------------------------------------------------------------------------
module grs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  grs_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output grs_pkg::rel_t                  rel,
  output logic                           ram_re,
  output logic [grs_pkg::RAM_AW-1:0]     ram_raddr,
  input  logic [grs_pkg::DATA_WIDTH-1:0] ram_rdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [grs_pkg::VALUE_W-1:0]    out_value,
  output logic                           group_last,
  output logic                           sequence_last
);

  grs_pkg::bk_state_t        state;
  grs_pkg::bk_state_t        state_next;
  logic                      bank;
  logic [grs_pkg::IDX_W-1:0] idx;
  logic                      eos;
  logic                      rd_pend;
  logic                      pend_glast;
  logic                      pend_slast;
  logic                      out_free;
  logic                      issue;
  logic                      last_rd;

  // outputs
  always_comb begin
    out_free = !out_valid || !out_stall;
    issue    = 1'b0;
    unique case (state)
      grs_pkg::BK_IDLE:  issue = 1'b0;
      grs_pkg::BK_DRAIN: issue = !rd_pend || out_free;
      default:           issue = 1'b0;
    endcase
    last_rd   = issue && (idx == '0);
    q_pop     = q_valid && ((state == grs_pkg::BK_IDLE) || last_rd);
    rel.valid = last_rd;
    rel.bank  = bank;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      grs_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = grs_pkg::BK_DRAIN;
        end
      end
      grs_pkg::BK_DRAIN: begin
        if (last_rd && !q_valid) begin
          state_next = grs_pkg::BK_IDLE;
        end
      end
      default: state_next = grs_pkg::BK_IDLE;
    endcase
  end

  assign ram_re    = issue;
  assign ram_raddr = {bank, idx};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bank <= q_cmd.bank;
      idx  <= grs_pkg::IDX_W'(q_cmd.count - grs_pkg::CNT_W'(1));
      eos  <= q_cmd.eos;
    end else if (issue) begin
      idx <= idx - grs_pkg::IDX_W'(1);
    end
    if (issue) begin
      pend_glast <= (idx == '0);
      pend_slast <= (idx == '0) && eos;
    end
    if (out_free && rd_pend) begin
      out_value     <= grs_pkg::VALUE_W'(ram_rdata);
      group_last    <= pend_glast;
      sequence_last <= pend_slast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= grs_pkg::BK_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      // read data held in the RAM register until the output slot frees up
      rd_pend <= issue || (rd_pend && !out_free);
      if (out_free) begin
        out_valid <= rd_pend;
      end
    end
  end

endmodule

[rtl/group_reverse_stream.sv]
// ----------------------------------------------------------------------------
// group_reverse_stream
// Re-emits a stream of values with each group of group_size values reversed.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with value and end_of_sequence. Output
// channel: out_valid / out_stall with out_value, group_last and sequence_last.
// group_size is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the block is idle, not enforced by the block; 0 or 1 passes values
// straight through, values above 16 act as 16. Values are stored in one of two
// RAM banks; a finished group is queued as a drain command and read back newest
// first while the other bank fills. A group's command passes the command queue
// and drain state; its values pass the RAM read register and output register,
// one value per cycle unless the output stalls. One transaction per cycle
// unless stalled, set by the single RAM read port, pausing when the drain side
// runs dry between groups. in_stall rises while the fill bank holds a group not
// yet read back. A stalled output keeps its transaction in the output register;
// the read data waits in the RAM register and the drain side pauses behind it.
// Reset: group_size returns to 1, buffers are empty, no output is valid.
// ----------------------------------------------------------------------------
module group_reverse_stream (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [grs_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          value,
  input  logic                        end_of_sequence,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_value,
  output logic                        group_last,
  output logic                        sequence_last
);

  logic                                ram_we;
  logic [grs_pkg::RAM_AW-1:0]          ram_waddr;
  logic [grs_pkg::DATA_WIDTH-1:0]      ram_wdata;
  logic                                ram_re;
  logic [grs_pkg::RAM_AW-1:0]          ram_raddr;
  logic [grs_pkg::DATA_WIDTH-1:0]      ram_rdata;
  logic                                cmd_push;
  grs_pkg::cmd_t                       cmd;
  logic                                q_valid;
  grs_pkg::cmd_t                       q_cmd;
  logic                                q_pop;
  logic [grs_pkg::QCNT_W-1:0]          q_count;
  grs_pkg::rel_t                       rel;
  logic [grs_pkg::CNT_W-1:0]           fill_level;
  logic [grs_pkg::VALUE_W-1:0]         out_bits;

  grs_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .value           (value),
    .end_of_sequence (end_of_sequence),
    .rel             (rel),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .cmd_push        (cmd_push),
    .cmd             (cmd),
    .fill_level      (fill_level)
  );

  grs_ram #(
    .WIDTH (grs_pkg::DATA_WIDTH),
    .DEPTH (grs_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  grs_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .count      (q_count)
  );

  grs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .rel           (rel),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_bits),
    .group_last    (group_last),
    .sequence_last (sequence_last)
  );

  assign out_value = out_bits;

  // a full group always flushes, so the fill count never reaches the bank size
  assert property (@(posedge clk) disable iff (rst)
    fill_level < grs_pkg::CNT_W'(grs_pkg::GROUP_MAX))
    else $error("fill count reached bank size");

  // two banks bound the outstanding commands, so the queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    cmd_push && !q_pop |-> q_count < grs_pkg::QCNT_W'(grs_pkg::QUEUE_DEPTH))
    else $error("command queue overflow");

  // end of sequence only ever closes a group
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_last |-> group_last)
    else $error("sequence_last without group_last");

  // nothing to drain means nothing popped
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("pop from empty command queue");

endmodule
